// File: hdl/ipv4dq_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types, codes and constants shared by the dotted-quad checker modules.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY_OCTET  = 3'd1,
    ST_NO_DIGITS    = 3'd2,
    ST_OVER_255     = 3'd3,
    ST_LEADING_ZERO = 3'd4,
    ST_BAD_CHAR     = 3'd5,
    ST_BAD_FORMAT   = 3'd6
  } status_t;

  localparam logic [8:0] MaxOctet     = 9'd255;
  localparam logic [8:0] SatValue     = 9'd256;
  localparam logic [1:0] DigitsMax    = 2'd3;
  localparam logic [2:0] CountMax     = 3'd7;
  localparam logic [2:0] DotsNeeded   = 3'd3;
  localparam logic [2:0] OctetsNeeded = 3'd4;
  localparam logic [7:0] CharDot      = 8'h2e;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;

  typedef struct packed {
    logic [8:0] octet_value;
    logic [1:0] digits_seen;
    logic       first_is_zero;
    logic [2:0] dots_seen;
    logic [2:0] octets_seen;
    status_t    error_code;
  } chk_state_t;

  localparam chk_state_t StateReset = '{
    octet_value:   9'd0,
    digits_seen:   2'd0,
    first_is_zero: 1'b0,
    dots_seen:     3'd0,
    octets_seen:   3'd0,
    error_code:    ST_OK
  };

endpackage

// File: hdl/ipv4_dotted_quad_checker.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker
// Streams a dotted-decimal IPv4 string one character per transaction and
// reports one status transaction for each string, on its last character.
// ----------------------------------------------------------------------------
// A last character passes the input register, then loads the result register.
// Throughput: one character per cycle; the input register stalls only while
// a finished status is held by out_stall and another last character waits.
// Reset (rst_n low, synchronous): both registers empty, checker state cleared.
module ipv4_dotted_quad_checker import ipv4dq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_has_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_has_r;
  logic       s1_last_r;
  logic       s1_advance;
  logic       out_free;

  chk_state_t state_r;
  chk_state_t state_nxt;
  status_t    step_status;
  logic       out_valid_r;
  status_t    out_status_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall   = s1_valid_r && !s1_advance;

  ipv4dq_step u_step (
    .cur_state (state_r),
    .char_code (s1_char_r),
    .has_char  (s1_has_r),
    .last      (s1_last_r),
    .nxt_state (state_nxt),
    .status    (step_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char_r <= in_char_code;
      s1_has_r  <= in_has_char;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateReset;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // result register; a last character only advances when it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last_r) begin
      out_status_r <= step_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

// File: hdl/ipv4dq_step.sv
// ----------------------------------------------------------------------------
// ipv4dq_step
// Per-character update of the checker state and end-of-string status.
// ----------------------------------------------------------------------------
module ipv4dq_step import ipv4dq_pkg::*; (
  input  chk_state_t cur_state,
  input  logic [7:0] char_code,
  input  logic       has_char,
  input  logic       last,
  output chk_state_t nxt_state,
  output status_t    status
);

  // finish the open octet: range and leading-zero checks, then count it
  function automatic chk_state_t close_octet(input chk_state_t s);
    chk_state_t r;
    r = s;
    if (s.octet_value > MaxOctet) begin
      r.error_code = ST_OVER_255;
    end else if (s.first_is_zero && (s.digits_seen > 2'd1)) begin
      r.error_code = ST_LEADING_ZERO;
    end else begin
      r.octets_seen = (s.octets_seen == CountMax) ? CountMax : s.octets_seen + 3'd1;
    end
    r.octet_value   = 9'd0;
    r.digits_seen   = 2'd0;
    r.first_is_zero = 1'b0;
    return r;
  endfunction

  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [12:0] times_ten;
  chk_state_t  s;

  assign is_digit  = (char_code >= CharZero) && (char_code <= CharNine);
  assign is_dot    = (char_code == CharDot);
  assign digit     = 4'(char_code - CharZero);
  assign times_ten = {1'b0, cur_state.octet_value, 3'b000}
                   + {3'b000, cur_state.octet_value, 1'b0}
                   + {9'd0, digit};

  always_comb begin
    s = cur_state;
    if (has_char && (cur_state.error_code == ST_OK)) begin
      if (is_digit) begin
        if ((cur_state.digits_seen == 2'd0) && (digit == 4'd0)) begin
          s.first_is_zero = 1'b1;
        end
        if (cur_state.octet_value < SatValue) begin
          s.octet_value = (times_ten > {4'd0, SatValue}) ? SatValue : times_ten[8:0];
        end
        if (cur_state.digits_seen < DigitsMax) begin
          s.digits_seen = cur_state.digits_seen + 2'd1;
        end
      end else if (cur_state.digits_seen == 2'd0) begin
        s.error_code = is_dot ? ST_EMPTY_OCTET : ST_NO_DIGITS;
      end else begin
        s = close_octet(cur_state);
        if (s.error_code == ST_OK) begin
          if (is_dot) begin
            s.dots_seen = (s.dots_seen == CountMax) ? CountMax : s.dots_seen + 3'd1;
          end else begin
            s.error_code = ST_BAD_CHAR;
          end
        end
      end
    end

    if (last) begin
      if ((s.error_code == ST_OK) && (s.digits_seen != 2'd0)) begin
        s = close_octet(s);
      end
      if ((s.error_code == ST_OK) &&
          ((s.dots_seen != DotsNeeded) || (s.octets_seen != OctetsNeeded))) begin
        s.error_code = ST_BAD_FORMAT;
      end
    end

    status    = s.error_code;
    nxt_state = last ? StateReset : s;
  end

endmodule

// File: bench/tb_ipv4_dotted_quad_checker.sv
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_quad_checker
// Streams dotted-quad strings into the checker one character per transaction
// and checks every status against a local predictor of the checker state.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_quad_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import ipv4dq_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       has;
    logic       fin;
  } chr_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'd0;
  logic       in_has_char = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;

  ipv4_dotted_quad_checker u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_has_char  (in_has_char),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status)
  );

  always #5 clk = ~clk;

  chr_item_t pending[$];
  chr_item_t draft[$];
  status_t   exp_status_q[$];

  // predicted checker state
  logic [8:0] p_value;
  logic [1:0] p_digits;
  logic       p_zero;
  logic [2:0] p_dots;
  logic [2:0] p_octets;
  status_t    p_err;

  int  n_items = 0;
  int  n_chars = 0;
  int  strings_in = 0;
  int  n_err = 0;
  int  status_seen[7];
  bit  in_acc = 1'b0;
  bit  out_acc = 1'b0;
  bit  offering = 1'b0;
  bit  long_hold = 1'b0;
  int  tx_gap = 0;
  int  tx_run = 0;
  int  rx_hold = 0;
  int  rx_run = 0;
  chr_item_t cur;

  function automatic chr_item_t mk(logic [7:0] c, logic h, logic f);
    chr_item_t it;
    it.code = c;
    it.has  = h;
    it.fin  = f;
    return it;
  endfunction

  function automatic logic [2:0] count_up(logic [2:0] v);
    return (v == CountMax) ? v : v + 3'd1;
  endfunction

  task report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    n_err++;
  endtask

  task clear_octet();
    p_value  = 9'd0;
    p_digits = 2'd0;
    p_zero   = 1'b0;
  endtask

  task clear_checker();
    clear_octet();
    p_dots   = 3'd0;
    p_octets = 3'd0;
    p_err    = ST_OK;
  endtask

  task close_octet();
    if (p_value > MaxOctet) begin
      p_err = ST_OVER_255;
    end else if (p_zero && p_digits > 2'd1) begin
      p_err = ST_LEADING_ZERO;
    end else begin
      p_octets = count_up(p_octets);
    end
    clear_octet();
  endtask

  task feed_char(input logic [7:0] c);
    int t;
    if (c >= CharZero && c <= CharNine) begin
      if (p_digits == 2'd0 && c == CharZero) p_zero = 1'b1;
      if (p_value < SatValue) begin
        t = int'(p_value) * 10 + int'(c) - int'(CharZero);
        p_value = (t > int'(SatValue)) ? SatValue : 9'(t);
      end
      if (p_digits < DigitsMax) p_digits++;
    end else if (p_digits == 2'd0) begin
      if (c == CharDot) p_err = ST_EMPTY_OCTET;
      else p_err = ST_NO_DIGITS;
    end else begin
      close_octet();
      if (p_err == ST_OK) begin
        if (c == CharDot) p_dots = count_up(p_dots);
        else p_err = ST_BAD_CHAR;
      end
    end
  endtask

  // one accepted character transaction; a status is due on the last one
  task take_char(input chr_item_t it);
    if (it.has) n_chars++;
    if (it.has && p_err == ST_OK) feed_char(it.code);
    if (it.fin) begin
      if (p_err == ST_OK && p_digits != 2'd0) close_octet();
      if (p_err == ST_OK && (p_dots != DotsNeeded || p_octets != OctetsNeeded))
        p_err = ST_BAD_FORMAT;
      exp_status_q.push_back(p_err);
      status_seen[p_err]++;
      strings_in++;
      clear_checker();
    end
  endtask

  // wait draw with occasional runs of back-to-back transactions
  task draw_wait(inout int run, output int cycles);
    if (run > 0) begin
      run--;
      cycles = 0;
    end else begin
      if ($urandom_range(0, 29) == 0) run = $urandom_range(10, 40);
      cycles = $urandom_range(0, 15);
    end
  endtask

  task put_item(input chr_item_t it);
    pending.push_back(it);
    n_items++;
  endtask

  task put_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++)
      put_item(mk(s[i], 1'b1, fin && (i == s.len() - 1)));
  endtask

  function automatic logic [7:0] noise_byte();
    int pick = $urandom_range(0, 3);
    if (pick == 0) return CharDot;
    if (pick == 1) return 8'($urandom_range(int'(CharZero), int'(CharNine)));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic draft_octet();
    int pick = $urandom_range(0, 19);
    int v;
    string txt;
    if (pick < 12) v = $urandom_range(0, 255);
    else if (pick < 16) v = $urandom_range(245, 265);
    else v = $urandom_range(0, 99999);
    txt = $sformatf("%0d", v);
    if (pick == 11 || pick == 19) txt = {"0", txt};
    for (int i = 0; i < txt.len(); i++) draft.push_back(mk(txt[i], 1'b1, 1'b0));
  endtask

  // mostly well-formed quads with random content, some broken, some noise
  task automatic draft_string();
    int kind = $urandom_range(0, 9);
    int n_oct;
    int at;
    chr_item_t it;
    draft.delete();
    if (kind < 8) begin
      n_oct = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 4;
      for (int k = 0; k < n_oct; k++) begin
        if (k > 0) draft.push_back(mk(CharDot, 1'b1, 1'b0));
        draft_octet();
      end
      if ($urandom_range(0, 9) == 0) begin
        at = $urandom_range(0, draft.size());
        draft.insert(at, mk(CharDot, 1'b1, 1'b0));
      end
      if ($urandom_range(0, 7) == 0) begin
        at = $urandom_range(0, draft.size() - 1);
        it = draft[at];
        it.code = 8'($urandom_range(0, 255));
        draft[at] = it;
      end
    end else begin
      repeat ($urandom_range(0, 10)) draft.push_back(mk(noise_byte(), 1'b1, 1'b0));
    end
    if ($urandom_range(0, 5) == 0 && draft.size() != 0) begin
      at = $urandom_range(0, draft.size());
      draft.insert(at, mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    end
    if (draft.size() == 0 || $urandom_range(0, 4) == 0) begin
      draft.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end else begin
      it = draft[draft.size() - 1];
      it.fin = 1'b1;
      draft[draft.size() - 1] = it;
    end
    foreach (draft[i]) put_item(draft[i]);
  endtask

  // sampling side: predictor fed on input transactions, check on results
  always @(posedge clk) begin
    status_t want;
    in_acc  <= rst_n && in_valid && !in_stall;
    out_acc <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        take_char(mk(in_char_code, in_has_char, in_last));
      if (out_valid && !out_stall) begin
        if (exp_status_q.size() == 0) begin
          report_mismatch($sformatf("status %0d with no string pending", out_status));
        end else begin
          want = exp_status_q.pop_front();
          if (out_status !== want)
            report_mismatch($sformatf("status %0d, predicted %0d", out_status, want));
        end
      end
    end
  end

  // character driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (offering && in_acc) begin
        offering = 1'b0;
        draw_wait(tx_run, tx_gap);
        if (long_hold) tx_gap = 0;
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() != 0) begin
          cur = pending.pop_front();
          in_char_code <= cur.code;
          in_has_char  <= cur.has;
          in_last      <= cur.fin;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // status receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) draw_wait(rx_run, rx_hold);
      else if (rx_hold > 0 && out_valid) rx_hold--;
      out_stall <= long_hold || (rx_hold > 0);
    end
  end

  // long receiver hold-off so the checker backs up into its input
  initial begin
    wait (strings_in >= 30);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (250) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clear_checker();
    foreach (status_seen[i]) status_seen[i] = 0;
    // directed strings
    put_item(mk(8'h00, 1'b0, 1'b1));          // empty string
    put_text(".", 1'b1);                      // dot where an octet starts
    put_item(mk(8'hff, 1'b1, 1'b1));          // non-digit where an octet starts
    put_text("1.", 1'b1);                     // trailing dot
    put_text("256", 1'b1);
    put_text("99999", 1'b1);                  // saturating digit run
    put_text("01", 1'b1);
    put_text("1", 1'b0);                      // NUL as a bad character, then
    put_item(mk(8'h00, 1'b1, 1'b0));          // a byte after the error and an
    put_text("5", 1'b0);                      // empty terminator
    put_item(mk(8'haa, 1'b0, 1'b1));
    put_text("255.0", 1'b0);
    put_item(mk(8'h55, 1'b0, 1'b0));          // empty item mid-string
    put_text(".9.1", 1'b1);
    while (n_items < 630) draft_string();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || offering || exp_status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d strings (%0d characters) including a long output hold-off.",
             strings_in, n_chars);
    $display("Statuses ok/empty/nodig/over/lead/badchar/format: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
